// ===== hw/rtl/line_convolution_bad_mask_macros.svh =====
// ----------------------------------------------------------------------------
// line_convolution_bad_mask_macros.svh
// Assertion macros for the line convolution RTL.
// ----------------------------------------------------------------------------
`ifndef LINE_CONVOLUTION_BAD_MASK_MACROS_SVH
`define LINE_CONVOLUTION_BAD_MASK_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, clocked on aclk, off during reset
`define LCBM_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lcbm assertion failed");

// next-cycle implication, clocked on aclk, off during reset
`define LCBM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lcbm assertion failed");

`else

`define LCBM_ASSERT_IMPL(name, ante, cons)
`define LCBM_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ===== hw/rtl/lcbm_pkg.sv =====
// ----------------------------------------------------------------------------
// lcbm_pkg
// Constants and types of the line convolution block.
// ----------------------------------------------------------------------------
package lcbm_pkg;

    localparam int MAX_TAPS  = 101;
    localparam int SAMPLE_W  = 32;
    localparam int COEF_W    = 18;
    localparam int COEF_FRAC = 16;
    localparam int TAP_IDX_W = 7;
    localparam int KLEN_W    = 7;
    localparam int CNT_W     = 7;
    localparam int HALF_W    = $clog2((MAX_TAPS - 1) / 2 + 1);
    localparam int ROT_W     = $clog2(MAX_TAPS);

    localparam int PROD_W = SAMPLE_W + COEF_W;
    localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS);
    localparam int RND_W  = ACC_W - COEF_FRAC;

    // input tdata layout, lowest field first
    localparam int TAP_IDX_LSB = 0;
    localparam int TAP_VAL_LSB = TAP_IDX_LSB + TAP_IDX_W;
    localparam int SAMPLE_LSB  = TAP_VAL_LSB + COEF_W;
    localparam int S_TDATA_W   = ((SAMPLE_LSB + SAMPLE_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((SAMPLE_W + 7) / 8) * 8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAD_ENABLE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAD_VALUE     = 2'd2;

    localparam logic [KLEN_W-1:0] KLEN_RESET = 7'd3;

    // item kind carried in s_tuser
    localparam logic FUNC_TAP    = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // broadcast control for the ring of cells
    typedef struct packed {
        logic                 shift;   // push a new sample in at cell 0
        logic                 rotate;  // move samples and taps one cell around the ring
        logic                 clear;   // zero every sample (line end)
        logic                 tap_we;  // write one tap
        logic [TAP_IDX_W-1:0] tap_idx;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/line_convolution_bad_mask.sv =====
// ----------------------------------------------------------------------------
// line_convolution_bad_mask
// Line smoother: 1-D convolution with a loadable kernel of up to 101 taps.
// Input stream: s_tuser selects tap write (0) or line sample (1); s_tlast marks
// the last sample of a line. One result transfer per line position on m_*,
// m_tlast on the final one. Config via cfg_wr_en/cfg_index/cfg_data.
// Timing: a tap write, or a sample that neither completes a result nor
// ends its line, leaves the input ready again in the next cycle. A sample
// that completes a result holds the input through the accepting cycle, one
// full turn of the tap ring through the single MAC, the drain of the
// product register and the load of the output register; m_tvalid rises
// with that load. Each flush result after the line's last sample is made
// the same way, its first step spent pushing a trailing zero.
// The output register lets the next item enter while a result waits.
// Stall: if m_tready is low the block parks before loading the next result
// and takes no input until that result has left.
// Reset: registers return to kernel_length 3, skipping off, empty window;
// taps are undefined until written.
// ----------------------------------------------------------------------------
`include "line_convolution_bad_mask_macros.svh"

module line_convolution_bad_mask (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [lcbm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lcbm_pkg::CFG_DATA_W-1:0]       cfg_data,
    // input stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [lcbm_pkg::S_TDATA_W-1:0]        s_tdata,   // tap_index, tap_value, sample
    input  logic [0:0]                            s_tuser,   // func
    input  logic                                  s_tlast,   // last_in_line
    // result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [lcbm_pkg::M_TDATA_W-1:0]        m_tdata,   // smoothed
    output logic [0:0]                            m_tuser,   // saturated
    output logic                                  m_tlast    // last_out
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FLUSH  = 3'd1;   // push one trailing zero
    localparam logic [2:0] ST_ROTATE = 3'd2;   // full ring turn through the MAC
    localparam logic [2:0] ST_FINISH = 3'd3;   // last product into accumulator
    localparam logic [2:0] ST_EMIT   = 3'd4;   // wait for output register

    localparam int KW = lcbm_pkg::KLEN_W;
    localparam int CW = lcbm_pkg::CNT_W;
    localparam int HW = lcbm_pkg::HALF_W;
    localparam int RW = lcbm_pkg::ROT_W;

    // configuration registers
    logic [KW-1:0]                        klen_reg;
    logic                                 bad_en_reg;
    logic signed [lcbm_pkg::SAMPLE_W-1:0] bad_val_reg;

    // sequencer
    logic [2:0]    state_reg,     state_next;
    logic [RW-1:0] rot_reg,       rot_next;
    logic [CW-1:0] count_reg,     count_next;   // samples seen in this line
    logic [CW-1:0] p_reg,         p_next;       // position of newest sample
    logic [HW-1:0] z_reg,         z_next;       // trailing zeros pushed so far
    logic          line_last_reg, line_last_next;
    logic          res_last_reg,  res_last_next;

    // output register
    logic                                 m_valid_reg;
    logic signed [lcbm_pkg::SAMPLE_W-1:0] m_data_reg;
    logic                                 m_sat_reg;
    logic                                 m_last_reg;

    // input fields
    logic                                 in_func;
    logic [lcbm_pkg::TAP_IDX_W-1:0]       in_tap_idx;
    logic signed [lcbm_pkg::COEF_W-1:0]   in_tap_val;
    logic signed [lcbm_pkg::SAMPLE_W-1:0] in_sample;
    logic signed [lcbm_pkg::SAMPLE_W-1:0] masked_sample;

    logic          accept;
    logic          tap_acc;
    logic          smp_acc;
    logic          out_free;
    logic          emit_load;
    logic [KW-1:0] len_eff;
    logic [HW-1:0] half;
    logic [HW-1:0] z_inc;
    logic [CW:0]   reach;
    logic [KW:0]   rot_plus_len;

    lcbm_pkg::cell_ctrl_t                 cell_ctrl;
    logic signed [lcbm_pkg::SAMPLE_W-1:0] push_sample;
    logic signed [lcbm_pkg::SAMPLE_W-1:0] tail_sample;
    logic signed [lcbm_pkg::COEF_W-1:0]   tail_tap;
    logic                                 mac_clr;
    logic                                 mac_en;
    logic signed [lcbm_pkg::SAMPLE_W-1:0] mac_smoothed;
    logic                                 mac_sat;

    // ---- field unpacking -------------------------------------------------
    assign in_func    = s_tuser[0];
    assign in_tap_idx = s_tdata[lcbm_pkg::TAP_IDX_LSB +: lcbm_pkg::TAP_IDX_W];
    assign in_tap_val = s_tdata[lcbm_pkg::TAP_VAL_LSB +: lcbm_pkg::COEF_W];
    assign in_sample  = s_tdata[lcbm_pkg::SAMPLE_LSB +: lcbm_pkg::SAMPLE_W];

    // missing data enters the window as zero
    assign masked_sample = (bad_en_reg && (in_sample == bad_val_reg)) ? '0 : in_sample;

    // ---- handshakes -----------------------------------------------------
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign tap_acc   = accept && (in_func == lcbm_pkg::FUNC_TAP);
    assign smp_acc   = accept && (in_func == lcbm_pkg::FUNC_SAMPLE);
    assign out_free  = !m_valid_reg || m_tready;
    assign emit_load = (state_reg == ST_EMIT) && out_free;

    // ---- kernel geometry ------------------------------------------------
    // length clipped to the ring size, half-width rounds down
    assign len_eff = (klen_reg > KW'(lcbm_pkg::MAX_TAPS)) ? KW'(lcbm_pkg::MAX_TAPS) : klen_reg;
    assign half    = (len_eff == '0) ? '0 : HW'((len_eff - KW'(1)) >> 1);

    assign z_inc = z_reg + HW'(1);
    assign reach = (CW+1)'(p_reg) + (CW+1)'(z_inc);

    // ---- configuration ---------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            klen_reg    <= lcbm_pkg::KLEN_RESET;
            bad_en_reg  <= 1'b0;
            bad_val_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lcbm_pkg::REG_KERNEL_LENGTH: begin
                    klen_reg <= cfg_data[KW-1:0];
                end
                lcbm_pkg::REG_BAD_ENABLE: begin
                    bad_en_reg <= cfg_data[0];
                end
                lcbm_pkg::REG_BAD_VALUE: begin
                    bad_val_reg <= cfg_data[lcbm_pkg::SAMPLE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---- sequencer -------------------------------------------------------
    // A sample at position p yields result p-h once p >= h. After the marked
    // sample, h trailing zeros follow, those with p+z >= h yielding results.
    always_comb begin
        state_next     = state_reg;
        rot_next       = rot_reg;
        count_next     = count_reg;
        p_next         = p_reg;
        z_next         = z_reg;
        line_last_next = line_last_reg;
        res_last_next  = res_last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (smp_acc) begin
                    p_next         = count_reg;
                    line_last_next = s_tlast;
                    z_next         = '0;
                    if (count_reg != {CW{1'b1}}) begin
                        count_next = count_reg + CW'(1);
                    end
                    if (count_reg >= CW'(half)) begin
                        res_last_next = s_tlast && (half == '0);
                        state_next    = ST_ROTATE;
                    end else if (s_tlast) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                z_next = z_inc;
                if (reach >= (CW+1)'(half)) begin
                    res_last_next = (z_inc == half);
                    state_next    = ST_ROTATE;
                end
            end
            ST_ROTATE: begin
                if (rot_reg == RW'(lcbm_pkg::MAX_TAPS - 1)) begin
                    rot_next   = '0;
                    state_next = ST_FINISH;
                end else begin
                    rot_next = rot_reg + RW'(1);
                end
            end
            ST_FINISH: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    if (res_last_reg) begin
                        // line done: window and count start over
                        state_next     = ST_IDLE;
                        count_next     = '0;
                        line_last_next = 1'b0;
                        z_next         = '0;
                    end else if (line_last_reg) begin
                        state_next = ST_FLUSH;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rot_reg       <= '0;
            count_reg     <= '0;
            p_reg         <= '0;
            z_reg         <= '0;
            line_last_reg <= 1'b0;
            res_last_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rot_reg       <= rot_next;
            count_reg     <= count_next;
            p_reg         <= p_next;
            z_reg         <= z_next;
            line_last_reg <= line_last_next;
            res_last_reg  <= res_last_next;
        end
    end

    // ---- ring of cells ---------------------------------------------------
    assign cell_ctrl.shift   = smp_acc || (state_reg == ST_FLUSH);
    assign cell_ctrl.rotate  = (state_reg == ST_ROTATE);
    assign cell_ctrl.clear   = emit_load && res_last_reg;
    assign cell_ctrl.tap_we  = tap_acc && (in_tap_idx < lcbm_pkg::TAP_IDX_W'(lcbm_pkg::MAX_TAPS));
    assign cell_ctrl.tap_idx = in_tap_idx;

    assign push_sample = (state_reg == ST_FLUSH) ? '0 : masked_sample;

    lcbm_chain u_chain (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (cell_ctrl),
        .new_sample  (push_sample),
        .tap_wdata   (in_tap_val),
        .tail_sample (tail_sample),
        .tail_tap    (tail_tap)
    );

    // ---- MAC -------------------------------------------------------------
    // At rotation step r the tail holds window[MAX_TAPS-1-r]; it counts when
    // that position is inside the kernel, i.e. r + len >= MAX_TAPS.
    assign rot_plus_len = (KW+1)'(rot_reg) + (KW+1)'(len_eff);
    assign mac_en  = (state_reg == ST_ROTATE) && (rot_plus_len >= (KW+1)'(lcbm_pkg::MAX_TAPS));
    assign mac_clr = (state_reg == ST_IDLE) || (state_reg == ST_FLUSH);

    lcbm_mac u_mac (
        .aclk      (aclk),
        .clr       (mac_clr),
        .en        (mac_en),
        .sample_in (tail_sample),
        .tap_in    (tail_tap),
        .smoothed  (mac_smoothed),
        .saturated (mac_sat)
    );

    // ---- output register -------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_load) begin
            m_data_reg <= mac_smoothed;
            m_sat_reg  <= mac_sat;
            m_last_reg <= res_last_reg;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = lcbm_pkg::M_TDATA_W'(m_data_reg);
    assign m_tuser[0] = m_sat_reg;
    assign m_tlast    = m_last_reg;

    // ---- assertions ------------------------------------------------------
    // ring must be back at rest whenever a new item can enter
    `LCBM_ASSERT_IMPL(a_ring_home, state_reg == ST_IDLE, rot_reg == '0)
    // final result of a line empties the window and the count
    `LCBM_ASSERT_NEXT(a_line_cleared, emit_load && res_last_reg, count_reg == '0 && tail_sample == '0)
    // trailing zeros only after a marked sample
    `LCBM_ASSERT_IMPL(a_flush_in_line, state_reg == ST_FLUSH, line_last_reg)
    // a pending result is never dropped while the receiver stalls
    `LCBM_ASSERT_NEXT(a_emit_waits, (state_reg == ST_EMIT) && !out_free, state_reg == ST_EMIT)

endmodule

// ===== hw/rtl/lcbm_cell.sv =====
// ----------------------------------------------------------------------------
// lcbm_cell
// One ring position: holds a window sample and a kernel tap.
// ----------------------------------------------------------------------------
module lcbm_cell (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  lcbm_pkg::cell_ctrl_t                 ctrl,
    input  logic                                 sel,
    input  logic signed [lcbm_pkg::SAMPLE_W-1:0] sample_in,
    input  logic signed [lcbm_pkg::COEF_W-1:0]   tap_in,
    input  logic signed [lcbm_pkg::COEF_W-1:0]   tap_wdata,
    output logic signed [lcbm_pkg::SAMPLE_W-1:0] sample_q,
    output logic signed [lcbm_pkg::COEF_W-1:0]   tap_q
);

    logic signed [lcbm_pkg::SAMPLE_W-1:0] sample_reg;
    logic signed [lcbm_pkg::COEF_W-1:0]   tap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= '0;
        end else if (ctrl.clear) begin
            sample_reg <= '0;
        end else if (ctrl.shift || ctrl.rotate) begin
            sample_reg <= sample_in;
        end
    end

    // taps stay put on a sample shift, travel only with a rotation
    always_ff @(posedge aclk) begin
        if (ctrl.rotate) begin
            tap_reg <= tap_in;
        end else if (sel) begin
            tap_reg <= tap_wdata;
        end
    end

    assign sample_q = sample_reg;
    assign tap_q    = tap_reg;

endmodule

// ===== hw/rtl/lcbm_chain.sv =====
// ----------------------------------------------------------------------------
// lcbm_chain
// Ring of MAX_TAPS cells; cell j holds window[j] and tap[j] when at rest.
// ----------------------------------------------------------------------------
module lcbm_chain (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  lcbm_pkg::cell_ctrl_t                 ctrl,
    input  logic signed [lcbm_pkg::SAMPLE_W-1:0] new_sample,
    input  logic signed [lcbm_pkg::COEF_W-1:0]   tap_wdata,
    output logic signed [lcbm_pkg::SAMPLE_W-1:0] tail_sample,
    output logic signed [lcbm_pkg::COEF_W-1:0]   tail_tap
);

    logic signed [lcbm_pkg::SAMPLE_W-1:0] smp    [lcbm_pkg::MAX_TAPS];
    logic signed [lcbm_pkg::SAMPLE_W-1:0] smp_in [lcbm_pkg::MAX_TAPS];
    logic signed [lcbm_pkg::COEF_W-1:0]   tp     [lcbm_pkg::MAX_TAPS];
    logic signed [lcbm_pkg::COEF_W-1:0]   tp_in  [lcbm_pkg::MAX_TAPS];
    logic [lcbm_pkg::MAX_TAPS-1:0]        sel;

    for (genvar j = 0; j < lcbm_pkg::MAX_TAPS; j++) begin : g_cell
        if (j == 0) begin : g_head
            // head closes the ring while rotating
            assign smp_in[j] = ctrl.rotate ? smp[lcbm_pkg::MAX_TAPS-1] : new_sample;
            assign tp_in[j]  = tp[lcbm_pkg::MAX_TAPS-1];
        end else begin : g_body
            assign smp_in[j] = smp[j-1];
            assign tp_in[j]  = tp[j-1];
        end

        assign sel[j] = ctrl.tap_we && (ctrl.tap_idx == lcbm_pkg::TAP_IDX_W'(j));

        lcbm_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .sel       (sel[j]),
            .sample_in (smp_in[j]),
            .tap_in    (tp_in[j]),
            .tap_wdata (tap_wdata),
            .sample_q  (smp[j]),
            .tap_q     (tp[j])
        );
    end

    assign tail_sample = smp[lcbm_pkg::MAX_TAPS-1];
    assign tail_tap    = tp[lcbm_pkg::MAX_TAPS-1];

endmodule

// ===== hw/rtl/lcbm_mac.sv =====
// ----------------------------------------------------------------------------
// lcbm_mac
// Multiply-accumulate on the ring tail, then round to Q16.16 and saturate.
// ----------------------------------------------------------------------------
module lcbm_mac (
    input  logic                                 aclk,
    input  logic                                 clr,
    input  logic                                 en,
    input  logic signed [lcbm_pkg::SAMPLE_W-1:0] sample_in,
    input  logic signed [lcbm_pkg::COEF_W-1:0]   tap_in,
    output logic signed [lcbm_pkg::SAMPLE_W-1:0] smoothed,
    output logic                                 saturated
);

    logic signed [lcbm_pkg::PROD_W-1:0]  prod_reg;
    logic signed [lcbm_pkg::ACC_W-1:0]   acc_reg;
    logic signed [lcbm_pkg::ACC_W-1:0]   biased;
    logic signed [lcbm_pkg::RND_W-1:0]   rnd;
    logic [lcbm_pkg::RND_W-lcbm_pkg::SAMPLE_W:0] upper;
    logic                                fits;

    // products of taps outside the kernel enter as zero
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= sample_in * tap_in;
        end else begin
            prod_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (clr) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_reg + lcbm_pkg::ACC_W'(prod_reg);
        end
    end

    // round half up, floor shift
    assign biased = acc_reg + (lcbm_pkg::ACC_W'(1) << (lcbm_pkg::COEF_FRAC - 1));
    assign rnd    = biased[lcbm_pkg::ACC_W-1:lcbm_pkg::COEF_FRAC];
    assign upper  = rnd[lcbm_pkg::RND_W-1:lcbm_pkg::SAMPLE_W-1];
    assign fits   = (&upper) || (~|upper);

    assign saturated = !fits;
    assign smoothed  = fits ? rnd[lcbm_pkg::SAMPLE_W-1:0]
                     : (rnd[lcbm_pkg::RND_W-1] ? {1'b1, {(lcbm_pkg::SAMPLE_W-1){1'b0}}}
                                               : {1'b0, {(lcbm_pkg::SAMPLE_W-1){1'b1}}});

endmodule
